>>> hw/rtl/drb_pkg.sv
// drb_pkg: beat types, field widths and sequencer states of the datagram ring buffer.
// No dependencies.
`timescale 1ns / 1ps
package drb_pkg;

	localparam int LEN_W = 9;
	localparam int MAC_W = 48;
	localparam int OFF_W = 11;
	localparam int WORD_W = 64;
	localparam int NB_W = 4;
	localparam int BB_CFG_W = 12;
	localparam int QE_CFG_W = 5;
	localparam int LANE_W = 3;

	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_PEEK = 2'd2;
	localparam logic [1:0] KIND_CONS = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TOO_LONG = 2'd1;
	localparam logic [1:0] ST_STALE = 2'd2;

	localparam logic CFG_BUF_BYTES = 1'b0;
	localparam logic CFG_QUEUE_ENTRIES = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [LEN_W-1:0] length;
		logic [MAC_W-1:0] source_mac;
		logic [OFF_W-1:0] expected_offset;
		logic [WORD_W-1:0] payload_word;
		logic [NB_W-1:0] payload_bytes;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic queue_drop;
		logic space_drop;
		logic head_valid;
		logic [OFF_W-1:0] head_offset;
		logic [LEN_W-1:0] head_length;
		logic [MAC_W-1:0] head_mac;
		logic [WORD_W-1:0] read_word;
		logic [NB_W-1:0] read_bytes;
		logic last;
	} out_beat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVICT,
		S_PLACE,
		S_FILL,
		S_RD_ADDR,
		S_RD_DATA,
		S_OUT
	} seq_state_t;

endpackage

>>> hw/rtl/datagram_ring_buffer_drop_oldest.sv
// Top level of the datagram ring buffer: sequencer, descriptor ring and wrap arithmetic.
// Depends on drb_pkg and drb_ram.
`timescale 1ns / 1ps
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  in      | in_valid, in_stall, in_data     | beats in, block drives in_stall
//  out     | out_valid, out_stall, out_data  | beats out, sink drives out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_index,| register writes, taken when idle
//          | cfg_data                        |
//
//  Peek, rejected header, and stale or empty consume go straight to the output beat.
//  A header evicts entries, one drop per cycle, then places its descriptor. A data word
//  stores its bytes one per cycle through the single byte port of the data ring. A consume
//  reads each byte in an address step and a data step and sends each word as an output beat.
//  Output beats wait in a register while out_stall is high.
//  arst_n clears pointers, counters and the sequencer; the data ring and descriptors
//  are not cleared and are never read before being written.
module datagram_ring_buffer_drop_oldest
	import drb_pkg::*;
#(
	parameter int BUF_BYTES = 2048,
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_LEN = 256,
	parameter int WORD_BYTES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_beat_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_beat_t           out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [BB_CFG_W-1:0] cfg_data
);
	localparam int AW = $clog2(BUF_BYTES);   // ring address
	localparam int CW = AW + 1;              // byte counts up to BUF_BYTES
	localparam int QW = $clog2(QUEUE_DEPTH); // descriptor index
	localparam int NW = QW + 1;              // entry count

	// sequencer
	seq_state_t state_q, state_nx;

	// config registers
	logic [BB_CFG_W-1:0] buf_bytes_q;
	logic [QE_CFG_W-1:0] queue_entries_q;

	// queue state
	logic [QW-1:0] head_q;
	logic [NW-1:0] count_q;
	logic [CW-1:0] used_q;
	logic [AW-1:0] wp_q;
	logic [LEN_W-1:0] fill_rem_q;
	logic [LEN_W-1:0] fill_len_q;

	// descriptor ring: read only at the head
	logic [AW-1:0] desc_off_q [QUEUE_DEPTH];
	logic [LEN_W-1:0] desc_len_q [QUEUE_DEPTH];
	logic [MAC_W-1:0] desc_mac_q [QUEUE_DEPTH];

	// per-item working registers
	logic [LEN_W-1:0] hlen_q;
	logic [MAC_W-1:0] hmac_q;
	logic qd_q, sd_q;
	logic [WORD_W-1:0] shift_q;
	logic [NB_W-1:0] cnt_q;
	logic [LANE_W-1:0] lane_q;
	logic [LEN_W-1:0] total_q, done_q;
	logic [AW-1:0] pos_q;
	logic [WORD_W-1:0] word_q;
	logic more_q, drop_q;
	out_beat_t out_q, out_nx;

	// ram
	logic ram_we;
	logic [7:0] ram_rdata;

	drb_ram #(.DEPTH(BUF_BYTES), .AW(AW)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(shift_q[7:0]),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	// effective sizes, register 0 acts as 1, large values saturate
	logic [CW-1:0] bb;
	logic [NW-1:0] qn;
	always_comb begin
		if (buf_bytes_q == '0)
			bb = CW'(1);
		else if (32'(buf_bytes_q) > BUF_BYTES)
			bb = CW'(BUF_BYTES);
		else
			bb = CW'(buf_bytes_q);
		if (queue_entries_q == '0)
			qn = NW'(1);
		else if (32'(queue_entries_q) > QUEUE_DEPTH)
			qn = NW'(QUEUE_DEPTH);
		else
			qn = NW'(queue_entries_q);
	end

	logic in_acc, out_acc, cfg_acc;
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign cfg_acc = cfg_valid && cfg_ready;

	// head descriptor view
	logic hv;
	logic [AW-1:0] h_off;
	logic [LEN_W-1:0] h_len;
	logic [MAC_W-1:0] h_mac;
	assign hv = count_q != '0;
	assign h_off = desc_off_q[head_q];
	assign h_len = desc_len_q[head_q];
	assign h_mac = desc_mac_q[head_q];

	// decisions
	logic too_long, cons_bad, evict_q, evict_s, last_byte;
	logic [NB_W-1:0] nw_in, nw_cont, pb_n, fill_n;
	logic [LEN_W-1:0] rem;
	always_comb begin
		too_long = 32'(in_data.length) > 32'(bb) || 32'(in_data.length) > MAX_LEN;
		cons_bad = !hv || 32'(h_off) != 32'(in_data.expected_offset) ||
			h_len != in_data.length || h_mac != in_data.source_mac;
		evict_q = count_q >= qn;
		evict_s = hv && (32'(bb) - 32'(used_q)) < 32'(hlen_q);
		last_byte = cnt_q == NB_W'(1);
		nw_in = (32'(in_data.length) > WORD_BYTES) ? NB_W'(WORD_BYTES)
			: NB_W'(in_data.length);
		rem = total_q - done_q;
		nw_cont = (32'(rem) > WORD_BYTES) ? NB_W'(WORD_BYTES) : NB_W'(rem);
		pb_n = (32'(in_data.payload_bytes) > WORD_BYTES) ? NB_W'(WORD_BYTES)
			: in_data.payload_bytes;
		fill_n = (32'(pb_n) > 32'(fill_rem_q)) ? NB_W'(fill_rem_q) : pb_n;
	end

	// wrap arithmetic: sums stay below twice the modulus
	logic [NW:0] slot_sum;
	logic [QW-1:0] slot, head_inc;
	logic [CW:0] off_sum;
	logic [AW-1:0] place_off, wp_inc, pos_inc;
	always_comb begin
		slot_sum = (NW+1)'(head_q) + (NW+1)'(count_q);
		slot = (slot_sum >= (NW+1)'(qn)) ? QW'(slot_sum - (NW+1)'(qn)) : QW'(slot_sum);
		head_inc = ((NW'(head_q) + NW'(1)) == qn) ? '0 : head_q + QW'(1);
		off_sum = (CW+1)'(h_off) + (CW+1)'(used_q);
		place_off = !hv ? '0
			: (off_sum >= (CW+1)'(bb)) ? AW'(off_sum - (CW+1)'(bb)) : AW'(off_sum);
		wp_inc = (CW'(wp_q) + CW'(1) == bb) ? '0 : wp_q + AW'(1);
		pos_inc = (CW'(pos_q) + CW'(1) == bb) ? '0 : pos_q + AW'(1);
	end

	// read word with the arriving byte in its lane
	logic [WORD_W-1:0] word_nx;
	always_comb begin
		for (int j = 0; j < WORD_W / 8; j++) begin
			word_nx[j*8 +: 8] = (LANE_W'(j) == lane_q) ? ram_rdata : word_q[j*8 +: 8];
		end
	end

	// next output beat
	always_comb begin
		out_nx = out_q;
		case (state_q)
			S_IDLE: begin
				out_nx = '0;
				out_nx.last = 1'b1;
				if (in_data.kind == KIND_HDR) begin
					out_nx.status = ST_TOO_LONG;
				end else if (in_data.kind == KIND_PEEK ||
					(in_data.kind == KIND_CONS && (cons_bad || nw_in == '0))) begin
					out_nx.status = (in_data.kind == KIND_CONS && cons_bad) ? ST_STALE : ST_OK;
					out_nx.head_valid = hv;
					out_nx.head_offset = hv ? OFF_W'(h_off) : '0;
					out_nx.head_length = hv ? h_len : '0;
					out_nx.head_mac = hv ? h_mac : '0;
				end
			end
			S_PLACE: begin
				out_nx = '0;
				out_nx.status = ST_OK;
				out_nx.queue_drop = qd_q;
				out_nx.space_drop = sd_q;
				out_nx.last = 1'b1;
			end
			S_RD_DATA: begin
				if (last_byte) begin
					out_nx = '0;
					out_nx.status = ST_OK;
					out_nx.head_valid = 1'b1;
					out_nx.head_offset = OFF_W'(h_off);
					out_nx.head_length = h_len;
					out_nx.head_mac = h_mac;
					out_nx.read_word = word_nx;
					out_nx.read_bytes = NB_W'(lane_q) + NB_W'(1);
					out_nx.last = (done_q + LEN_W'(1)) == total_q;
				end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (in_data.kind)
						KIND_HDR:  state_nx = too_long ? S_OUT : S_EVICT;
						KIND_DATA: state_nx = (fill_rem_q != '0 && fill_n != '0) ? S_FILL : S_IDLE;
						KIND_PEEK: state_nx = S_OUT;
						KIND_CONS: state_nx = (cons_bad || nw_in == '0) ? S_OUT : S_RD_ADDR;
						default:   state_nx = S_IDLE;
					endcase
				end
			end
			S_EVICT:   state_nx = (evict_q || evict_s) ? S_EVICT : S_PLACE;
			S_PLACE:   state_nx = S_OUT;
			S_FILL:    state_nx = last_byte ? S_IDLE : S_FILL;
			S_RD_ADDR: state_nx = S_RD_DATA;
			S_RD_DATA: state_nx = last_byte ? S_OUT : S_RD_ADDR;
			S_OUT: begin
				if (out_acc)
					state_nx = more_q ? S_RD_ADDR : S_IDLE;
			end
			default:   state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = (state_q != S_IDLE) || cfg_valid;
		cfg_ready = state_q == S_IDLE;
		out_valid = state_q == S_OUT;
		out_data = out_q;
		ram_we = state_q == S_FILL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_bytes_q <= BB_CFG_W'(2048);
			queue_entries_q <= QE_CFG_W'(16);
			head_q <= '0;
			count_q <= '0;
			used_q <= '0;
			wp_q <= '0;
			fill_rem_q <= '0;
			more_q <= 1'b0;
			drop_q <= 1'b0;
		end else if (cfg_acc) begin
			case (cfg_index)
				CFG_BUF_BYTES:     buf_bytes_q <= cfg_data;
				CFG_QUEUE_ENTRIES: queue_entries_q <= cfg_data[QE_CFG_W-1:0];
				default:           buf_bytes_q <= cfg_data;
			endcase
			head_q <= '0;
			count_q <= '0;
			used_q <= '0;
			wp_q <= '0;
			fill_rem_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_data.kind == KIND_HDR && !too_long)
							fill_rem_q <= '0;
						if (in_data.kind == KIND_CONS) begin
							more_q <= 1'b0;
							drop_q <= !cons_bad;
						end else begin
							more_q <= 1'b0;
							drop_q <= 1'b0;
						end
					end
				end
				S_EVICT: begin
					if (evict_q || evict_s) begin
						used_q <= used_q - CW'(h_len);
						head_q <= head_inc;
						count_q <= count_q - NW'(1);
					end
				end
				S_PLACE: begin
					wp_q <= place_off;
					if (hlen_q == '0)
						count_q <= count_q + NW'(1);
					else
						fill_rem_q <= hlen_q;
				end
				S_FILL: begin
					wp_q <= wp_inc;
					fill_rem_q <= fill_rem_q - LEN_W'(1);
					if (fill_rem_q == LEN_W'(1)) begin
						used_q <= used_q + CW'(fill_len_q);
						count_q <= count_q + NW'(1);
					end
				end
				S_RD_DATA: begin
					if (last_byte)
						more_q <= (done_q + LEN_W'(1)) != total_q;
				end
				S_OUT: begin
					if (out_acc && drop_q && !more_q) begin
						used_q <= used_q - CW'(h_len);
						head_q <= head_inc;
						count_q <= count_q - NW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// descriptor writes and payload working registers
	always_ff @(posedge clk) begin
		out_q <= out_nx;
		case (state_q)
			S_IDLE: begin
				hlen_q <= in_data.length;
				hmac_q <= in_data.source_mac;
				qd_q <= 1'b0;
				sd_q <= 1'b0;
				shift_q <= in_data.payload_word;
				cnt_q <= (in_data.kind == KIND_DATA) ? fill_n : nw_in;
				lane_q <= '0;
				word_q <= '0;
				total_q <= in_data.length;
				done_q <= '0;
				pos_q <= h_off;
			end
			S_EVICT: begin
				if (evict_q)
					qd_q <= 1'b1;
				else if (evict_s)
					sd_q <= 1'b1;
			end
			S_PLACE: begin
				desc_off_q[slot] <= place_off;
				desc_len_q[slot] <= hlen_q;
				desc_mac_q[slot] <= hmac_q;
				fill_len_q <= hlen_q;
			end
			S_FILL: begin
				shift_q <= shift_q >> 8;
				cnt_q <= cnt_q - NB_W'(1);
			end
			S_RD_DATA: begin
				word_q <= word_nx;
				pos_q <= pos_inc;
				lane_q <= lane_q + LANE_W'(1);
				cnt_q <= cnt_q - NB_W'(1);
				done_q <= done_q + LEN_W'(1);
			end
			S_OUT: begin
				if (out_acc) begin
					cnt_q <= nw_cont;
					lane_q <= '0;
					word_q <= '0;
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	// idle means no beat is waiting at the output
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid) else $error("output beat while accepting");

	// occupancy never exceeds the configured slots or bytes
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= qn) else $error("entry count above queue size");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= bb) else $error("used bytes above ring size");
`endif
endmodule

>>> hw/rtl/drb_ram.sv
// drb_ram: byte-wide data ring, one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module drb_ram #(
	parameter int DEPTH = 2048,
	parameter int AW = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> test/tb_datagram_ring_buffer_drop_oldest.sv
// Self-checking testbench for datagram_ring_buffer_drop_oldest: directed and random beats,
// register writes between phases, random idling on both channels. Depends on drb_pkg and the DUT.
`timescale 1ns / 1ps
module tb_datagram_ring_buffer_drop_oldest;
	import drb_pkg::*;

	localparam int RING = 2048;
	localparam int SLOTS = 16;
	localparam int LONGEST = 256;
	localparam int LANES = 8;
	localparam int SETTLE = 40;          // covers a full 8-byte data word store
	localparam int LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [BB_CFG_W-1:0] cfg_data = '0;

	always #5 clk = ~clk;

	datagram_ring_buffer_drop_oldest u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// ---- shadow copy of the store ----
	logic [7:0] ring_mem [RING];
	logic [OFF_W-1:0] slot_off [SLOTS];
	logic [LEN_W-1:0] slot_len [SLOTS];
	logic [MAC_W-1:0] slot_mac [SLOTS];
	int hd, cnt, used, wptr, fill;
	int cfg_bytes = 2048;
	int cfg_slots = 16;

	out_beat_t pending_beats [$];
	int errors = 0;
	int snd_idle = 0;
	int rcv_idle = 0;
	int cycles = 0;

	function automatic int ring_size();
		if (cfg_bytes == 0) return 1;
		if (cfg_bytes > RING) return RING;
		return cfg_bytes;
	endfunction

	function automatic int slot_count();
		if (cfg_slots == 0) return 1;
		if (cfg_slots > SLOTS) return SLOTS;
		return cfg_slots;
	endfunction

	function automatic void queue_beat(logic [1:0] st, logic qd, logic sd, logic with_head,
			logic [WORD_W-1:0] w, int nb, logic lst);
		out_beat_t r;
		int h;
		h = hd % slot_count();
		r = '0;
		r.status = st;
		r.queue_drop = qd;
		r.space_drop = sd;
		if (with_head && cnt > 0) begin
			r.head_valid = 1'b1;
			r.head_offset = slot_off[h];
			r.head_length = slot_len[h];
			r.head_mac = slot_mac[h];
		end
		r.read_word = w;
		r.read_bytes = nb[NB_W-1:0];
		r.last = lst;
		pending_beats.push_back(r);
	endfunction

	function automatic void pop_head();
		if (cnt == 0) return;
		used -= slot_len[hd % slot_count()];
		hd = (hd + 1) % slot_count();
		cnt--;
	endfunction

	function automatic void flush_store();
		hd = 0; cnt = 0; used = 0; wptr = 0; fill = 0;
	endfunction

	// expected beats caused by one accepted input beat
	function automatic void model_beat(in_beat_t b);
		int bb, q, len, n, h, pos, total, done, slot, off;
		logic qd, sd;
		logic [WORD_W-1:0] w;
		bb = ring_size();
		q = slot_count();
		len = b.length;
		case (b.kind)
			KIND_HDR: begin
				if (len > bb || len > LONGEST) begin
					queue_beat(ST_TOO_LONG, 0, 0, 0, '0, 0, 1);
				end else begin
					qd = 0; sd = 0;
					fill = 0;
					forever begin
						if (cnt >= q) begin
							qd = 1; pop_head();
						end else if (cnt > 0 && bb - used < len) begin
							sd = 1; pop_head();
						end else break;
					end
					off = cnt > 0 ? (slot_off[hd % q] + used) % bb : 0;
					slot = (hd + cnt) % q;
					slot_off[slot] = OFF_W'(off);
					slot_len[slot] = LEN_W'(len);
					slot_mac[slot] = b.source_mac;
					wptr = off;
					if (len == 0) cnt++;
					else fill = len;
					queue_beat(ST_OK, qd, sd, 0, '0, 0, 1);
				end
			end
			KIND_DATA: begin
				n = b.payload_bytes > LANES ? LANES : b.payload_bytes;
				if (fill != 0) begin
					if (n > fill) n = fill;
					for (int i = 0; i < n; i++) begin
						ring_mem[wptr % bb] = b.payload_word[8*i +: 8];
						wptr = (wptr + 1) % bb;
					end
					fill -= n;
					if (fill == 0) begin
						used += slot_len[(hd + cnt) % q];
						cnt++;
					end
				end
			end
			KIND_PEEK: queue_beat(ST_OK, 0, 0, 1, '0, 0, 1);
			default: begin
				h = hd % q;
				if (cnt == 0 || slot_off[h] != b.expected_offset || slot_len[h] != b.length ||
						slot_mac[h] != b.source_mac) begin
					queue_beat(ST_STALE, 0, 0, 1, '0, 0, 1);
				end else begin
					total = slot_len[h];
					pos = slot_off[h] % bb;
					done = 0;
					do begin
						n = total - done;
						if (n > LANES) n = LANES;
						w = '0;
						for (int i = 0; i < n; i++) begin
							w[8*i +: 8] = ring_mem[pos];
							pos = (pos + 1) % bb;
						end
						done += n;
						queue_beat(ST_OK, 0, 0, 1, w, n, done >= total);
					end while (done < total);
					pop_head();
				end
			end
		endcase
	endfunction

	// ---- result checker ----
	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_beats.size() == 0) begin
				$display("%0t unexpected beat: expected none actual %h", $time, out_data);
				errors++;
			end else begin
				e = pending_beats.pop_front();
				check_field("status", e.status, out_data.status);
				check_field("queue_drop", e.queue_drop, out_data.queue_drop);
				check_field("space_drop", e.space_drop, out_data.space_drop);
				check_field("head_valid", e.head_valid, out_data.head_valid);
				check_field("head_offset", e.head_offset, out_data.head_offset);
				check_field("head_length", e.head_length, out_data.head_length);
				check_field("head_mac", e.head_mac, out_data.head_mac);
				check_field("read_word", e.read_word, out_data.read_word);
				check_field("read_bytes", e.read_bytes, out_data.read_bytes);
				check_field("last", e.last, out_data.last);
			end
		end
	end

	// sink back-pressure, redrawn every cycle
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < rcv_idle);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL datagram_ring_buffer_drop_oldest");
			$finish;
		end
	end

	// ---- stimulus helpers ----
	// one input beat; valid stays high afterwards so back-to-back beats need no toggle
	task automatic send_beat(in_beat_t b);
		if ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		model_beat(b);
	endtask

	function automatic in_beat_t make_beat(logic [1:0] k, int len, logic [MAC_W-1:0] mac);
		in_beat_t b;
		b = '0;
		b.kind = k;
		b.length = len[LEN_W-1:0];
		b.source_mac = mac;
		b.expected_offset = OFF_W'($urandom);
		b.payload_word = {$urandom, $urandom};
		b.payload_bytes = NB_W'($urandom);
		return b;
	endfunction

	function automatic logic [MAC_W-1:0] rand_mac();
		return MAC_W'({$urandom, $urandom});
	endfunction

	// header plus the data words to fill it; cut short now and then
	task automatic send_datagram(int len, bit cut);
		in_beat_t b;
		int left;
		send_beat(make_beat(KIND_HDR, len, rand_mac()));
		left = len;
		while (left > 0) begin
			if (cut && $urandom_range(3) == 0) break;
			b = make_beat(KIND_DATA, 0, rand_mac());
			b.payload_bytes = NB_W'(($urandom_range(3) == 0) ? $urandom_range(15) : LANES);
			send_beat(b);
			left -= (b.payload_bytes > LANES) ? LANES : b.payload_bytes;
		end
	endtask

	// consume aimed at the current head, optionally with one field spoiled
	task automatic consume_head(bit spoil);
		in_beat_t b;
		int h;
		h = hd % slot_count();
		b = make_beat(KIND_CONS, 0, 0);
		if (cnt > 0) begin
			b.length = slot_len[h];
			b.source_mac = slot_mac[h];
			b.expected_offset = slot_off[h];
		end
		if (spoil) begin
			case ($urandom_range(2))
				0: b.length = LEN_W'(b.length ^ (1 << $urandom_range(LEN_W - 1)));
				1: b.source_mac = b.source_mac ^ (48'd1 << $urandom_range(MAC_W - 1));
				default: b.expected_offset =
					OFF_W'(b.expected_offset ^ (1 << $urandom_range(OFF_W - 1)));
			endcase
		end
		send_beat(b);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[BB_CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_BUF_BYTES) cfg_bytes = val & 'hFFF;
		else cfg_slots = val & 'h1F;
		flush_store();
	endtask

	// ---- tests ----
	task automatic test_directed();
		in_beat_t b;
		send_beat(make_beat(KIND_PEEK, 0, 0));                 // peek, empty
		send_beat(make_beat(KIND_CONS, 0, 0));                 // consume, empty
		send_beat(make_beat(KIND_DATA, 0, 0));                 // data, no reservation
		send_beat(make_beat(KIND_HDR, 0, '1));                 // zero length commits at once
		send_beat(make_beat(KIND_PEEK, 0, 0));
		consume_head(0);
		send_beat(make_beat(KIND_HDR, 257, '1));               // above MAX_LEN
		send_beat(make_beat(KIND_HDR, 511, 0));
		send_datagram(LONGEST, 0);                              // largest datagram
		b = make_beat(KIND_HDR, 5, 0);
		send_beat(b);
		b = make_beat(KIND_DATA, 0, 0);
		b.payload_word = '1;
		b.payload_bytes = 15;                                   // oversize word, clipped
		send_beat(b);
		send_beat(make_beat(KIND_HDR, 12, rand_mac()));        // pending reservation abandoned
		send_datagram(3, 0);
		consume_head(1);
		consume_head(0);
		consume_head(0);
		consume_head(0);
	endtask

	task automatic test_random(int n);
		int len;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					len = ($urandom_range(15) == 0) ? $urandom_range(LONGEST) :
						$urandom_range(40);
					send_datagram(len, $urandom_range(7) == 0);
				end
				4: send_beat(make_beat(KIND_PEEK, 0, 0));
				5, 6: consume_head($urandom_range(5) == 0);
				7: send_beat(make_beat(KIND_HDR, $urandom_range(511), rand_mac()));
				8: send_beat(make_beat(KIND_DATA, 0, 0));
				default: send_beat(make_beat(KIND_CONS, $urandom_range(511), rand_mac()));
			endcase
		end
	endtask

	task automatic test_config(int bytes, int slots, int n);
		write_reg(CFG_BUF_BYTES, bytes);
		write_reg(CFG_QUEUE_ENTRIES, slots);
		test_random(n);
	endtask

	initial begin
		flush_store();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle = 10; rcv_idle = 64;
		test_directed();
		test_random(30);
		test_config(64, 4, 20);
		snd_idle = 64; rcv_idle = 10;
		test_config(1, 1, 10);                 // smallest ring and queue
		test_config(4095, 0, 15);              // saturating size, zero slots
		test_config(300, 31, 30);
		snd_idle = 0; rcv_idle = 0;
		test_config(0, 2, 10);
		test_config(2048, 16, 30);
		test_config(100, 3, 25);
		drain();

		if (errors == 0)
			$display("PASS datagram_ring_buffer_drop_oldest");
		else
			$display("FAIL datagram_ring_buffer_drop_oldest");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/drb_pkg.sv
hw/rtl/drb_ram.sv
hw/rtl/datagram_ring_buffer_drop_oldest.sv
test/tb_datagram_ring_buffer_drop_oldest.sv
